// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- sv/sha256_pkg.sv -----
// package: sha-256 constants, types and round functions
package sha256_pkg;
   localparam int QueueDepth = 4;

   typedef enum logic [2:0] {
      ENG_IDLE, ENG_LOAD, ENG_ROUND, ENG_ADD, ENG_PAD, ENG_EMIT
   } eng_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } item_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction
endpackage

// ----- sv/sha256_if.sv -----
// valid/ready channel interfaces
interface sha256_req_if;
   import sha256_pkg::*;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic has_byte;
   logic end_of_message;
   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- sv/sha256_queue.sv -----
// small fifo between input front and hashing engine
module sha256_queue
   import sha256_pkg::*;
#(
   parameter int Depth = QueueDepth
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);
   localparam int AW = $clog2(Depth);
   item_type         mem_ff [Depth];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;

   assign full     = (cnt_ff == Depth[AW:0]);
   assign empty    = (cnt_ff == '0);
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in  = (wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      rd_in  = (rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_in;
         if (pop) rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ----- sv/sha256_engine.sv -----
// back end: block packing, padding, compression rounds and digest output
module sha256_engine
   import sha256_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   sha256_rsp_if.source rsp
);
   eng_state_type state_ff, state_in;
   logic [31:0] blk_ff [16];
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [63:0] len_ff;
   logic [5:0]  pos_ff;
   logic [5:0]  rnd_ff;
   logic        fin_ff;       // message still needs its padding
   logic        second_ff;    // a length-only block still follows
   logic        last_blk_ff;  // block in the rounds is the final one
   logic [2:0]  out_ff;

   logic [31:0] s0, s1, wnew, wcur, t1, t2;
   logic [31:0] a, b, c, d, e, f, g, h;
   logic        overflow;

   // window shifts: w_ff[0] is the word for rounds 0 to 15; later rounds use the word computed from the window
   always_comb begin
      a = v_ff[0]; b = v_ff[1]; c = v_ff[2]; d = v_ff[3];
      e = v_ff[4]; f = v_ff[5]; g = v_ff[6]; h = v_ff[7];
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = s1 + w_ff[9] + s0 + w_ff[0];
      wcur = (rnd_ff < 6'd16) ? w_ff[0] : wnew;
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[rnd_ff] + wcur;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      overflow = (pos_ff >= LEN_POS);
   end

   always_comb begin
      state_in = state_ff;
      item_pop = 1'b0;
      case (state_ff)
         ENG_IDLE: if (item_valid) begin
            item_pop = 1'b1;
            if (item.has_byte && pos_ff == 6'd63) state_in = ENG_LOAD;
            else if (item.end_of_message) state_in = ENG_PAD;
         end
         ENG_LOAD:  state_in = ENG_ROUND;
         ENG_ROUND: if (rnd_ff == 6'd63) state_in = ENG_ADD;
         ENG_ADD: begin
            if (last_blk_ff) state_in = ENG_EMIT;
            else if (second_ff) state_in = ENG_LOAD;
            else if (fin_ff) state_in = ENG_PAD;
            else state_in = ENG_IDLE;
         end
         ENG_PAD:   state_in = ENG_LOAD;
         ENG_EMIT:  if (rsp.ready && out_ff == 3'd7) state_in = ENG_IDLE;
         default:   state_in = ENG_IDLE;
      endcase
   end

   assign rsp.valid       = (state_ff == ENG_EMIT);
   assign rsp.digest_word = h_ff[out_ff];
   assign rsp.word_index  = out_ff;
   assign rsp.last_word   = (out_ff == 3'd7);

   // control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_HASH[i];
         len_ff <= '0; pos_ff <= '0; rnd_ff <= '0; out_ff <= '0;
         fin_ff <= 1'b0; second_ff <= 1'b0; last_blk_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ENG_IDLE: if (item_valid) begin
               fin_ff <= item.end_of_message;
               if (item.has_byte) begin
                  len_ff <= len_ff + 64'd8;
                  pos_ff <= pos_ff + 6'd1;
               end
            end
            ENG_LOAD:  rnd_ff <= '0;
            ENG_ROUND: rnd_ff <= rnd_ff + 6'd1;
            ENG_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               if (last_blk_ff) begin
                  last_blk_ff <= 1'b0;
                  out_ff <= '0;
               end else if (second_ff) begin
                  second_ff <= 1'b0;
                  last_blk_ff <= 1'b1;
               end
            end
            ENG_PAD: begin
               fin_ff <= 1'b0;
               if (overflow) second_ff <= 1'b1;
               else last_blk_ff <= 1'b1;
            end
            ENG_EMIT: if (rsp.ready) begin
               out_ff <= out_ff + 3'd1;
               if (out_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= INIT_HASH[i];
                  len_ff <= '0; pos_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // block, schedule window and round variables
   always_ff @(posedge clock) begin
      if (!reset) begin
         case (state_ff)
            ENG_IDLE: if (item_valid && item.has_byte) begin
               blk_ff[pos_ff[5:2]][{~pos_ff[1:0], 3'b000} +: 8] <= item.data_byte;
            end
            ENG_LOAD: begin
               w_ff <= blk_ff;
               v_ff <= h_ff;
            end
            ENG_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wcur;
               v_ff[7] <= g; v_ff[6] <= f; v_ff[5] <= e; v_ff[4] <= d + t1;
               v_ff[3] <= c; v_ff[2] <= b; v_ff[1] <= a; v_ff[0] <= t1 + t2;
            end
            ENG_ADD: if (second_ff) begin
               for (int i = 0; i < 14; i++) blk_ff[i] <= '0;
               blk_ff[14] <= len_ff[63:32];
               blk_ff[15] <= len_ff[31:0];
            end
            // marker, zero fill, and the length when it fits
            ENG_PAD: begin
               for (int p = 0; p < 64; p++) begin
                  if (!overflow && p >= 56)
                     blk_ff[4'(p >> 2)][8*(3 - (p & 3)) +: 8] <= len_ff[8*(63 - p) +: 8];
                  else if (6'(p) == pos_ff)
                     blk_ff[4'(p >> 2)][8*(3 - (p & 3)) +: 8] <= PAD_MARKER;
                  else if (6'(p) > pos_ff)
                     blk_ff[4'(p >> 2)][8*(3 - (p & 3)) +: 8] <= 8'h00;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// ----- sv/sha256_message_digest.sv -----
// top level: streaming sha-256 digest
//
// req channel: one beat per message item (optional byte, end flag)
// rsp channel: eight beats of 32-bit digest words after the end beat
// a 4-entry queue decouples the front from the hashing engine
// byte beats are absorbed in the engine's idle state; a beat completing a 64-byte
// block also runs a load, 64 rounds on one shared round unit and one
// chaining add; an end beat adds a padding step, one or two blocks
// of that kind, then the 8 digest beats
// reset restores the initial hash, clears length and byte position
// a stalled receiver holds the engine; the queue keeps taking beats
// until full, then req ready drops
// from an end beat to the first digest word the engine runs pad, load,
// rounds and add, with a second load, rounds and add when the length spills
// into a second block, and a full block first when that beat completes one
module sha256_message_digest
   import sha256_pkg::*;
#(
   parameter int QDepth = QueueDepth
) (
   input logic clock,
   input logic reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);
   `include "assert_macros.svh"
   item_type in_item, q_item;
   logic q_full, q_empty, q_pop;

   assign in_item = '{data_byte: req.data_byte, has_byte: req.has_byte,
                      end_of_message: req.end_of_message};
   assign req.ready = !q_full;

   sha256_queue #(.Depth(QDepth)) u_queue (
      .clock, .reset, .push(req.valid && !q_full), .push_item(in_item),
      .full(q_full), .pop(q_pop), .pop_item(q_item), .empty(q_empty));

   sha256_engine u_engine (
      .clock, .reset, .item_valid(!q_empty), .item(q_item), .item_pop(q_pop),
      .rsp(rsp));

   `ASSERT_IMPL(a_no_pop_empty, clock, reset, q_pop, !q_empty)
   `ASSERT_IMPL(a_ready_full, clock, reset, q_full, !req.ready)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.digest_word) && $stable(rsp.word_index))
   `ASSERT_NEXT(a_last_idx, clock, reset, rsp.valid && rsp.ready && rsp.last_word, !rsp.valid)
endmodule

// ----- bench/sha256_tb_if.sv -----
// testbench package: digest scoreboard with a software sha-256
package sha256_tb_pkg;
   import sha256_pkg::*;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   // scoreboard: software sha-256 and queue of expected digest beats
   class digest_scoreboard_type;
      logic [31:0] chain [8];
      logic [31:0] blk [16];
      logic [63:0] bit_count;
      logic [5:0]  byte_pos;
      digest_beat_type pending_words [$];
      int errors;

      function void clear_message();
         chain = INIT_HASH;
         bit_count = '0;
         byte_pos = '0;
      endfunction

      function void compress();
         logic [31:0] w [64];
         logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
         for (int i = 0; i < 16; i++) w[i] = blk[i];
         for (int i = 16; i < 64; i++) begin
            s0 = {w[i-15][6:0], w[i-15][31:7]} ^ {w[i-15][17:0], w[i-15][31:18]}
                 ^ (w[i-15] >> 3);
            s1 = {w[i-2][16:0], w[i-2][31:17]} ^ {w[i-2][18:0], w[i-2][31:19]}
                 ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
         end
         {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                     chain[4], chain[5], chain[6], chain[7]};
         for (int r = 0; r < 64; r++) begin
            t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
                 + ((e & f) ^ (~e & g)) + ROUND_K[r] + w[r];
            t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
                 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
         chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
      endfunction

      function void put_byte(int p, logic [7:0] v);
         blk[p/4][(3 - p%4)*8 +: 8] = v;
      endfunction

      // note one accepted input beat
      function void absorb(logic [7:0] data, logic has, logic fin);
         digest_beat_type beat;
         if (has) begin
            put_byte(byte_pos, data);
            bit_count += 64'd8;
            byte_pos++;
            if (byte_pos == 0) compress();
         end
         if (!fin) return;
         put_byte(byte_pos, PAD_MARKER);
         for (int p = byte_pos + 1; p < 64; p++) put_byte(p, 8'h00);
         if (byte_pos >= LEN_POS) begin
            compress();
            for (int i = 0; i < 16; i++) blk[i] = '0;
         end
         blk[14] = bit_count[63:32];
         blk[15] = bit_count[31:0];
         compress();
         for (int i = 0; i < 8; i++) begin
            beat.digest_word = chain[i];
            beat.word_index = 3'(i);
            beat.last_word = (i == 7);
            pending_words = {pending_words, beat};
         end
         clear_message();
      endfunction

      // check one result beat against the oldest expectation
      function void check(logic [31:0] dw, logic [2:0] wi, logic lw);
         digest_beat_type exp_beat;
         if (pending_words.size() == 0) begin
            $error("digest beat with nothing expected: %h", dw);
            errors++;
            return;
         end
         exp_beat = pending_words.pop_front();
         if (dw !== exp_beat.digest_word) begin
            $error("digest_word expected %h actual %h", exp_beat.digest_word, dw);
            errors++;
         end
         if (wi !== exp_beat.word_index) begin
            $error("word_index expected %0d actual %0d", exp_beat.word_index, wi);
            errors++;
         end
         if (lw !== exp_beat.last_word) begin
            $error("last_word expected %0d actual %0d", exp_beat.last_word, lw);
            errors++;
         end
      endfunction
   endclass
endpackage

// ----- bench/testbench.sv -----
// testbench for the streaming sha-256 digest block
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sha256_pkg::*;
   import sha256_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int send_idle_pct = 10;
   int recv_idle_pct = 73;
   bit stall_request = 1'b0;  // asks the receiver for one long stall
   bit stall_taken = 1'b0;
   int hold_off = 0;          // cycles left in a long receiver stall
   int sent_items = 0;
   digest_scoreboard_type board;

   sha256_req_if req ();
   sha256_rsp_if rsp ();

   sha256_message_digest DUT (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random ready at the falling edge, with one long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp.ready <= 1'b0;
      end else if (stall_request && !stall_taken) begin
         hold_off <= 400;
         stall_taken <= 1'b1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // results are sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check(rsp.digest_word, rsp.word_index, rsp.last_word);
   end

   // offer one beat and hold it until accepted
   task automatic send_item(logic [7:0] data, logic has, logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.data_byte <= data;
      req.has_byte <= has;
      req.end_of_message <= fin;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.absorb(data, has, fin);
      sent_items++;
      @(negedge clock);
   endtask

   // a message of n bytes with random content, gap beats mixed in if with_gaps
   task automatic send_message(int n, bit with_gaps);
      for (int i = 0; i < n; i++) begin
         if (with_gaps && $urandom_range(7) == 0)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, (i == n - 1) && $urandom_range(1));
      end
      // close the message unless the last byte already did
      if (board.byte_pos != 0 || board.bit_count != 0 || n == 0)
         send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic random_phase(int items);
      int n;
      int start;
      start = sent_items;
      while (sent_items - start < items) begin
         case ($urandom_range(9))
            0: n = 0;
            1: n = 55 + $urandom_range(10);   // around the padding overflow
            2: n = 64 + $urandom_range(64);
            default: n = $urandom_range(40);
         endcase
         send_message(n, $urandom_range(1));
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.data_byte = '0;
      req.has_byte = 1'b0;
      req.end_of_message = 1'b0;
      board = new();
      board.clear_message();
      for (int i = 0; i < 16; i++) board.blk[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty message, "abc", extreme bytes, padding boundaries
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b0);   // no byte, not final: ignored data
      send_item(8'h5a, 1'b0, 1'b1);   // end with no byte
      send_item(8'haa, 1'b1, 1'b1);
      send_item(8'h55, 1'b1, 1'b1);
      send_message(55, 1'b0);         // marker plus length fit in one block
      send_message(56, 1'b0);         // padding overflow into a second block
      send_message(64, 1'b0);         // full block then padding-only block

      // long receiver stall while the sender keeps offering
      stall_request = 1'b1;
      random_phase(30);

      random_phase(65);
      send_idle_pct = 73;
      recv_idle_pct = 10;
      random_phase(65);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(65);
      req.valid <= 1'b0;

      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
